### hdl/lpht_pkg.sv
// Package: shared widths, codes and control/status types of the linear probe hash table.
package lpht_pkg;

    // Field widths fixed by the block's interface
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 12;
    localparam int PROBE_W  = 13;
    localparam int HASH_W   = 32;

    localparam int TABLE_LOG2_DEF = 12;
    localparam logic [HASH_W-1:0] HASH_MULT_RESET = 32'd472882027;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FETCH  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 2'd3;

    // Result word selection
    typedef logic [2:0] t_res_sel;
    localparam t_res_sel RES_OK_EMPTY = 3'd0;  // ok, all other fields zero
    localparam t_res_sel RES_ZERO_KEY = 3'd1;
    localparam t_res_sel RES_INS_OK   = 3'd2;
    localparam t_res_sel RES_FETCH_OK = 3'd3;
    localparam t_res_sel RES_MISS     = 3'd4;  // fetch hit an empty slot
    localparam t_res_sel RES_FULL     = 3'd5;  // insert wrapped the table
    localparam t_res_sel RES_WRAP     = 3'd6;  // fetch wrapped the table

    // Controller -> datapath
    typedef struct packed {
        logic     capture;      // latch request, start hash multiply
        logic     home;         // slot <= home slot, steps <= 0
        logic     sweep_start;  // slot <= 0
        logic     advance;      // slot++, steps++
        logic     wr_key;       // write key/value at current slot
        logic     wr_clear;     // write zero at current slot
        logic     res_load;     // load output word
        t_res_sel res_sel;
    } t_ctl_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             key_zero;
        logic             slot_empty;
        logic             key_match;
        logic             last_slot;
        logic             last_step;
    } t_dp_sts;

endpackage

### hdl/lpht_intf.sv
// Interfaces: request, result and configuration channels of the hash table.
interface lpht_in_if;
    import lpht_pkg::*;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] lookup_key;
    logic [VAL_W-1:0] store_value;
    modport source (output valid, output command, output lookup_key, output store_value,
                    input ready);
    modport sink   (input valid, input command, input lookup_key, input store_value,
                    output ready);
endinterface

interface lpht_out_if;
    import lpht_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    fetched_value;
    logic [SLOT_W-1:0]   slot_index;
    logic [PROBE_W-1:0]  probe_count;
    modport source (output valid, output status, output fetched_value, output slot_index,
                    output probe_count, input ready);
    modport sink   (input valid, input status, input fetched_value, input slot_index,
                    input probe_count, output ready);
endinterface

interface lpht_cfg_if;
    import lpht_pkg::*;
    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] hash_multiplier;
    modport source (output valid, output hash_multiplier, input ready);
    modport sink   (input valid, input hash_multiplier, output ready);
endinterface

### hdl/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpht_ram #(
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    localparam int DEPTH = 2 ** ADDR_W;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/lpht_datapath.sv
// Datapath: hash multiplier, slot/step counters, table RAM and the output word register.
module lpht_datapath #(
    parameter int TABLE_LOG2 = lpht_pkg::TABLE_LOG2_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lpht_pkg::t_ctl_cmd             i_cmd,
    output lpht_pkg::t_dp_sts              o_sts,
    input  logic                           i_cfg_wr,
    input  logic [lpht_pkg::HASH_W-1:0]    i_cfg_data,
    input  logic [lpht_pkg::CMD_W-1:0]     i_command,
    input  logic [lpht_pkg::KEY_W-1:0]     i_lookup_key,
    input  logic [lpht_pkg::VAL_W-1:0]     i_store_value,
    output logic [lpht_pkg::STATUS_W-1:0]  o_status,
    output logic [lpht_pkg::VAL_W-1:0]     o_fetched_value,
    output logic [lpht_pkg::SLOT_W-1:0]    o_slot_index,
    output logic [lpht_pkg::PROBE_W-1:0]   o_probe_count
);
    import lpht_pkg::*;

    localparam int ENTRY_W = KEY_W + VAL_W;

    logic [HASH_W-1:0]     r_mult;
    logic [CMD_W-1:0]      r_cmd;
    logic [KEY_W-1:0]      r_key;
    logic [VAL_W-1:0]      r_val;
    logic [HASH_W-1:0]     r_prod;
    logic [HASH_W-1:0]     prod_lo;
    logic [TABLE_LOG2-1:0] r_slot, n_slot;
    logic [TABLE_LOG2-1:0] r_steps, n_steps;
    logic [TABLE_LOG2-1:0] home_slot;

    logic                  ram_we;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [KEY_W-1:0]      rd_key;
    logic [VAL_W-1:0]      rd_val;

    logic [TABLE_LOG2:0]   probe_steps;
    logic [TABLE_LOG2:0]   probe_wrap;
    logic [31:0]           slot_wide;
    logic [31:0]           steps_wide;
    logic [31:0]           wrap_wide;

    logic [STATUS_W-1:0]   r_status, n_status;
    logic [VAL_W-1:0]      r_fval, n_fval;
    logic [SLOT_W-1:0]     r_oslot, n_oslot;
    logic [PROBE_W-1:0]    r_oprobe, n_oprobe;

    // Hash multiplier register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult <= HASH_MULT_RESET;
        end else if (i_cfg_wr) begin
            r_mult <= i_cfg_data;
        end
    end

    // Request capture; product is taken mod 2^32
    assign prod_lo = i_lookup_key * r_mult;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd  <= i_command;
            r_key  <= i_lookup_key;
            r_val  <= i_store_value;
            r_prod <= prod_lo;
        end
    end

    assign home_slot = r_prod[HASH_W-1 -: TABLE_LOG2];

    // Slot and step counters; slot wraps naturally at the table end
    always_comb begin
        n_slot  = r_slot;
        n_steps = r_steps;
        if (i_cmd.home) begin
            n_slot  = home_slot;
            n_steps = '0;
        end else if (i_cmd.sweep_start) begin
            n_slot  = '0;
        end else if (i_cmd.advance) begin
            n_slot  = r_slot + 1'b1;
            n_steps = r_steps + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_steps <= '0;
        end else begin
            r_slot  <= n_slot;
            r_steps <= n_steps;
        end
    end

    // Table: read address is the next slot, so read data always matches r_slot
    assign ram_we    = i_cmd.wr_key | i_cmd.wr_clear;
    assign ram_wdata = i_cmd.wr_clear ? '0 : {r_key, r_val};

    lpht_ram #(
        .WIDTH  (ENTRY_W),
        .ADDR_W (TABLE_LOG2)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (ram_wdata),
        .i_raddr (n_slot),
        .o_rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[ENTRY_W-1 -: KEY_W];
    assign rd_val = ram_rdata[VAL_W-1:0];

    assign o_sts.command    = r_cmd;
    assign o_sts.key_zero   = (r_key == '0);
    assign o_sts.slot_empty = (rd_key == '0);
    assign o_sts.key_match  = (rd_key == r_key);
    assign o_sts.last_slot  = &r_slot;
    assign o_sts.last_step  = &r_steps;

    // Output word; slot and probe count are masked to the port widths
    assign probe_steps = (TABLE_LOG2 + 1)'(r_steps);
    assign probe_wrap  = {1'b1, {TABLE_LOG2{1'b0}}};
    assign slot_wide   = 32'(r_slot);
    assign steps_wide  = 32'(probe_steps);
    assign wrap_wide   = 32'(probe_wrap);

    always_comb begin
        n_status = ST_OK;
        n_fval   = '0;
        n_oslot  = '0;
        n_oprobe = '0;
        unique case (i_cmd.res_sel)
            RES_OK_EMPTY: begin
                n_status = ST_OK;
            end
            RES_ZERO_KEY: begin
                n_status = ST_ZERO_KEY;
            end
            RES_INS_OK: begin
                n_oslot  = slot_wide[SLOT_W-1:0];
                n_oprobe = steps_wide[PROBE_W-1:0];
            end
            RES_FETCH_OK: begin
                n_fval   = rd_val;
                n_oslot  = slot_wide[SLOT_W-1:0];
                n_oprobe = steps_wide[PROBE_W-1:0];
            end
            RES_MISS: begin
                n_status = ST_NOT_FOUND;
                n_oprobe = steps_wide[PROBE_W-1:0];
            end
            RES_FULL: begin
                n_status = ST_FULL;
                n_oprobe = wrap_wide[PROBE_W-1:0];
            end
            RES_WRAP: begin
                n_status = ST_NOT_FOUND;
                n_oprobe = wrap_wide[PROBE_W-1:0];
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_status <= n_status;
            r_fval   <= n_fval;
            r_oslot  <= n_oslot;
            r_oprobe <= n_oprobe;
        end
    end

    assign o_status        = r_status;
    assign o_fetched_value = r_fval;
    assign o_slot_index    = r_oslot;
    assign o_probe_count   = r_oprobe;
endmodule

### hdl/lpht_ctrl.sv
// Controller: request sequencing, probe loop, clear sweep and output valid.
module lpht_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  lpht_pkg::t_dp_sts  i_sts,
    output lpht_pkg::t_ctl_cmd o_cmd
);
    import lpht_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_PROBE    = 3'd2;
    localparam logic [2:0] S_CLEAR    = 3'd3;
    localparam logic [2:0] S_CLR_DONE = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_clr_cmd, n_clr_cmd;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    // Output register may be refilled in the cycle it is taken
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state   = r_state;
        n_clr_cmd = r_clr_cmd;
        o_cmd     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.command)
                    CMD_CLEAR: begin
                        o_cmd.sweep_start = 1'b1;
                        n_clr_cmd         = 1'b1;
                        n_state           = S_CLEAR;
                    end
                    CMD_NOP: begin
                        if (out_free) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_sel  = RES_OK_EMPTY;
                            n_state        = S_IDLE;
                        end
                    end
                    default: begin
                        if (i_sts.key_zero) begin
                            if (out_free) begin
                                o_cmd.res_load = 1'b1;
                                o_cmd.res_sel  = RES_ZERO_KEY;
                                n_state        = S_IDLE;
                            end
                        end else begin
                            o_cmd.home = 1'b1;
                            n_state    = S_PROBE;
                        end
                    end
                endcase
            end
            S_PROBE: begin
                if (i_sts.command == CMD_INSERT) begin
                    if (i_sts.slot_empty) begin
                        if (out_free) begin
                            o_cmd.wr_key   = 1'b1;
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_sel  = RES_INS_OK;
                            n_state        = S_IDLE;
                        end
                    end else if (i_sts.last_step) begin
                        if (out_free) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_sel  = RES_FULL;
                            n_state        = S_IDLE;
                        end
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end else begin
                    if (i_sts.key_match || i_sts.slot_empty || i_sts.last_step) begin
                        if (out_free) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_sel  = i_sts.key_match  ? RES_FETCH_OK :
                                             i_sts.slot_empty ? RES_MISS : RES_WRAP;
                            n_state        = S_IDLE;
                        end
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.wr_clear = 1'b1;
                o_cmd.advance  = 1'b1;
                if (i_sts.last_slot) begin
                    n_state = r_clr_cmd ? S_CLR_DONE : S_IDLE;
                end
            end
            S_CLR_DONE: begin
                if (out_free) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_OK_EMPTY;
                    n_clr_cmd      = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.res_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Reset starts the clearing sweep of the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cmd   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cmd   <= n_clr_cmd;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

### hdl/linear_probe_hash_table.sv
// Top level: open-addressing hash table with linear probing and multiply-shift hash.
//
// Usage notes
//  - i_in carries one request word: command (insert, fetch, clear, no-op), key, value.
//    A word is taken when valid and ready are both high; ready is high only while
//    the block is idle, so one request is in flight at a time.
//  - o_out carries one result word per request (status, value, slot, probe count)
//    from an output register. The next request is accepted while a result still
//    waits there; the block only stalls when a new result has to be loaded.
//  - i_cfg writes the hash multiplier; ready is always high. Write only while idle.
//  - Insert/fetch: the accept registers the request and its 32x32 hash product, the
//    dispatch state addresses the home slot, then the probe state checks one slot
//    at a time. Zero key and no-op skip the probe; dispatch loads their result.
//    A new insert/fetch is taken only after the last one has loaded its result.
//  - Clear sweeps the table RAM one slot per cycle, then loads its result.
//  - Reset: synchronous, active low. It loads the default multiplier and starts the
//    same sweep over every slot, during which no request is taken; config writes
//    are taken throughout.
//  - A stalled receiver holds the result in place; the probe stays parked on its
//    final slot until the output register frees up.
module linear_probe_hash_table #(
    parameter int TABLE_LOG2 = lpht_pkg::TABLE_LOG2_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpht_in_if.sink     i_in,
    lpht_out_if.source  o_out,
    lpht_cfg_if.sink    i_cfg
);
    import lpht_pkg::*;

    t_ctl_cmd ctl_cmd;
    t_dp_sts  dp_sts;
    logic     in_ready;
    logic     out_valid;

    // Configuration is single-register and never back-pressured
    assign i_cfg.ready = 1'b1;

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    lpht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (dp_sts),
        .o_cmd       (ctl_cmd)
    );

    lpht_datapath #(
        .TABLE_LOG2 (TABLE_LOG2)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctl_cmd),
        .o_sts           (dp_sts),
        .i_cfg_wr        (i_cfg.valid),
        .i_cfg_data      (i_cfg.hash_multiplier),
        .i_command       (i_in.command),
        .i_lookup_key    (i_in.lookup_key),
        .i_store_value   (i_in.store_value),
        .o_status        (o_out.status),
        .o_fetched_value (o_out.fetched_value),
        .o_slot_index    (o_out.slot_index),
        .o_probe_count   (o_out.probe_count)
    );
endmodule

### dv/tb.sv
// Testbench: the hash table checked against a shadow table and probe predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpht_pkg::*;

    localparam int TBL_LOG2   = TABLE_LOG2_DEF;
    localparam int SLOTS      = 1 << TBL_LOG2;
    // Longest silent stretch in a correct run is a clear sweep or a full-table probe
    // plus a result stall, or the post-reset sweep.
    localparam int IDLE_LIMIT = 20000;
    localparam int TAIL_WAIT  = 16;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    value;
        logic [SLOT_W-1:0]   slot;
        logic [PROBE_W-1:0]  probes;
    } t_lookup_result;

    // Shadow copy of the table; predicts one result word per accepted request and
    // checks the result words in order.
    class lpht_shadow_table;
        logic [HASH_W-1:0] multiplier;
        logic [KEY_W-1:0]  keys [SLOTS];
        logic [VAL_W-1:0]  vals [SLOTS];
        t_lookup_result    awaited_results [$];
        int                errors;

        function new();
            multiplier = HASH_MULT_RESET;
            wipe();
            errors = 0;
        endfunction

        function void wipe();
            foreach (keys[i]) begin
                keys[i] = '0;
                vals[i] = '0;
            end
        endfunction

        function void set_multiplier(logic [HASH_W-1:0] m);
            multiplier = m;
        endfunction

        // top TBL_LOG2 bits of the 32-bit product
        function logic [SLOT_W-1:0] home_of(logic [KEY_W-1:0] key);
            logic [HASH_W-1:0] prod;
            prod = key * multiplier;
            return SLOT_W'(prod >> (HASH_W - TBL_LOG2));
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void apply_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                    logic [VAL_W-1:0] val);
            t_lookup_result   res;
            logic [SLOT_W-1:0] slot;
            int               steps;
            bit               done;
            res   = '{status: ST_OK, value: '0, slot: '0, probes: '0};
            done  = 0;
            if (cmd == CMD_CLEAR) begin
                wipe();
            end else if (cmd == CMD_NOP) begin
                // nothing changes
            end else if (key == '0) begin
                res.status = ST_ZERO_KEY;
            end else begin
                slot = home_of(key);
                for (steps = 0; steps < SLOTS && !done; steps++) begin
                    if (cmd == CMD_INSERT) begin
                        if (keys[slot] == '0) begin
                            keys[slot] = key;
                            vals[slot] = val;
                            res.slot   = slot;
                            res.probes = PROBE_W'(steps);
                            done       = 1;
                        end
                    end else if (keys[slot] == key) begin
                        res.value  = vals[slot];
                        res.slot   = slot;
                        res.probes = PROBE_W'(steps);
                        done       = 1;
                    end else if (keys[slot] == '0) begin
                        res.status = ST_NOT_FOUND;
                        res.probes = PROBE_W'(steps);
                        done       = 1;
                    end
                    if (!done)
                        slot = slot + 1'b1;  // wraps at the table end
                end
                if (!done) begin
                    // walked every slot
                    res.status = (cmd == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
                    res.probes = PROBE_W'(SLOTS);
                end
            end
            awaited_results.push_back(res);
        endfunction

        function void compare_result(t_lookup_result got);
            t_lookup_result exp;
            if (awaited_results.size() == 0) begin
                errors++;
                if (errors <= MAX_PRINTS)
                    $display("%0t ERROR unexpected result: status=%0d value=%h slot=%0d probes=%0d",
                             $time, got.status, got.value, got.slot, got.probes);
                return;
            end
            exp = awaited_results.pop_front();
            if (got.status !== exp.status || got.value !== exp.value ||
                got.slot !== exp.slot || got.probes !== exp.probes) begin
                errors++;
                if (errors <= MAX_PRINTS)
                    $display({"%0t ERROR result: expected status=%0d value=%h slot=%0d ",
                              "probes=%0d, got status=%0d value=%h slot=%0d probes=%0d"},
                             $time, exp.status, exp.value, exp.slot, exp.probes,
                             got.status, got.value, got.slot, got.probes);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lpht_in_if  in_ch ();
    lpht_out_if out_ch ();
    lpht_cfg_if cfg_ch ();

    linear_probe_hash_table uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    lpht_shadow_table shadow = new();

    // keys handed to insert since the last clear; fetch hits are drawn from here
    logic [KEY_W-1:0] live_keys [$];

    int tx_left  = 0;
    bit tx_burst = 0;
    int rx_left  = 0;
    bit rx_burst = 0;
    int idle_cycles = 0;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Gap before the next word: runs of back-to-back words are mixed at random with
    // runs of random gaps.
    function automatic int next_gap(inout int left, inout bit burst);
        if (left == 0) begin
            burst = ($urandom_range(0, 3) == 0);
            left  = $urandom_range(8, 40);
        end
        left--;
        return burst ? 0 : $urandom_range(0, 11);
    endfunction

    // Random nonzero key whose home slot lies within span slots from lo (mod table size).
    function automatic logic [KEY_W-1:0] key_near(int lo, int span);
        logic [KEY_W-1:0] k;
        int               tries;
        k = 32'd1;
        for (tries = 0; tries < 200000; tries++) begin
            k = $urandom;
            if (k != '0 && ((int'(shadow.home_of(k)) - lo) & (SLOTS - 1)) < span)
                break;
        end
        if (k == '0)
            k = 32'd1;
        return k;
    endfunction

    // A quarter of the keys land around the table end, to build clusters that wrap.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 3) == 0)
            return key_near(SLOTS - 4, 8);
        return $urandom;
    endfunction

    // Request channel: one word per call, after a random gap.
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] val);
        int gap;
        gap = next_gap(tx_left, tx_burst);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.command     <= cmd;
        in_ch.lookup_key  <= key;
        in_ch.store_value <= val;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (cmd == CMD_CLEAR)
            live_keys.delete();
        else if (cmd == CMD_INSERT && key != '0)
            live_keys.push_back(key);
    endtask

    // Multiplier writes only once every result is back, so the table is idle.
    task automatic write_multiplier(input logic [HASH_W-1:0] m);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (shadow.pending() != 0) @(posedge clk);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.hash_multiplier <= m;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_mix(input int count);
        int               r;
        logic [KEY_W-1:0] k;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r == 0) begin
                issue(CMD_CLEAR, $urandom, $urandom);
            end else if (r <= 2) begin
                issue(CMD_NOP, $urandom, $urandom);
            end else if (r <= 5) begin
                issue((r % 2) ? CMD_INSERT : CMD_FETCH, '0, $urandom);
            end else if (r <= 45) begin
                // occasional duplicate insert of a key already stored
                if (live_keys.size() != 0 && $urandom_range(0, 9) == 0)
                    k = live_keys[$urandom_range(0, live_keys.size() - 1)];
                else
                    k = pick_key();
                issue(CMD_INSERT, k, $urandom);
            end else if (r <= 80 && live_keys.size() != 0) begin
                issue(CMD_FETCH, live_keys[$urandom_range(0, live_keys.size() - 1)], $urandom);
            end else begin
                issue(CMD_FETCH, pick_key(), $urandom);
            end
        end
    endtask

    // Monitors: every handshake is sampled at the edge that completes it.
    always @(posedge clk) begin
        if (rst_n && in_ch.valid && in_ch.ready)
            shadow.apply_request(in_ch.command, in_ch.lookup_key, in_ch.store_value);
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
            shadow.set_multiplier(cfg_ch.hash_multiplier);
        if (rst_n && out_ch.valid && out_ch.ready)
            shadow.compare_result('{status: out_ch.status, value: out_ch.fetched_value,
                                    slot: out_ch.slot_index, probes: out_ch.probe_count});
    end

    // Watchdog: too long with no word moving on any channel ends the run.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ERROR timeout, %0d results outstanding", $time, shadow.pending());
            $display("FAIL linear_probe_hash_table");
            $finish;
        end
    end

    // Result channel: random stall before each word, with stall-free runs.
    initial begin : result_sink
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            gap = next_gap(rx_left, rx_burst);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    initial begin : stimulus
        logic [KEY_W-1:0] kw;
        logic [KEY_W-1:0] k;
        rst_n                  <= 1'b0;
        in_ch.valid            <= 1'b0;
        in_ch.command          <= CMD_NOP;
        in_ch.lookup_key       <= '0;
        in_ch.store_value      <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.hash_multiplier <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, under the reset multiplier: zero keys, field extremes,
        // duplicates, a cluster that wraps past the last slot, no-op and clear.
        issue(CMD_INSERT, '0, '1);
        issue(CMD_FETCH, '0, '1);
        issue(CMD_FETCH, '1, '0);          // empty table: miss at the home slot
        issue(CMD_INSERT, '1, '1);
        issue(CMD_FETCH, '1, '0);
        issue(CMD_INSERT, 32'd1, '0);
        issue(CMD_INSERT, 32'd1, 32'hA5A5_A5A5);  // second copy, first one wins on fetch
        issue(CMD_FETCH, 32'd1, '0);
        kw = key_near(SLOTS - 1, 1);
        issue(CMD_INSERT, kw, 32'h1234_5678);
        k = key_near(SLOTS - 1, 1);
        issue(CMD_INSERT, k, 32'h0000_0001);     // wraps into slot 0
        k = key_near(SLOTS - 1, 1);
        issue(CMD_INSERT, k, 32'h8000_0000);
        issue(CMD_FETCH, k, '0);                 // hit after wrapping
        issue(CMD_FETCH, kw, '0);
        issue(CMD_FETCH, key_near(SLOTS - 1, 1), '0);  // miss at the end of the cluster
        issue(CMD_NOP, '1, '1);
        issue(CMD_NOP, '0, '0);
        issue(CMD_CLEAR, '1, '1);
        issue(CMD_FETCH, 32'd1, '0);
        issue(CMD_FETCH, kw, '0);

        run_mix(250);

        write_multiplier('1);
        run_mix(200);

        // zero multiplier: every key homes to slot 0, long probe chains
        write_multiplier('0);
        run_mix(120);

        write_multiplier($urandom | 32'd1);
        run_mix(250);

        write_multiplier($urandom);
        run_mix(150);

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (shadow.pending() != 0) @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (shadow.errors == 0)
            $display("PASS linear_probe_hash_table");
        else
            $display("FAIL linear_probe_hash_table");
        $finish;
    end

endmodule
